>>> rtl/ccgo_pkg.sv
package ccgo_pkg;

   // Alphabet and grouping constants
   localparam int unsigned ALPHA_SIZE    = 67;
   localparam int unsigned LINE_SYMBOLS  = 48;
   localparam int unsigned GROUP_SYMBOLS = 6;
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned IDX_W         = 7;
   localparam int unsigned LINE_W        = 6;
   localparam int unsigned GROUP_W       = 3;

   localparam logic [CHAR_W-1:0] SEP_GROUP = 8'h5F;  // underscore
   localparam logic [CHAR_W-1:0] SEP_LINE  = 8'h0A;  // newline

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [IDX_W-1:0]  index_type;

   // Separator that follows a cipher symbol
   typedef enum logic [1:0] {
      SEP_NONE,
      SEP_UNDERSCORE,
      SEP_NEWLINE
   } sep_type;

   // One queued symbol: its cipher index and the separator after it
   typedef struct packed {
      index_type sym_idx;
      sep_type   sep;
   } entry_type;

   typedef struct packed {
      logic      hit;
      index_type idx;
   } lookup_type;

   // Byte to alphabet index; hit is low for bytes outside the alphabet
   function automatic lookup_type char_lookup(input char_type c);
      lookup_type r;
      r.hit = 1'b1;
      r.idx = '0;
      case (c) inside
         [8'h30:8'h39]: r.idx = index_type'(c - 8'h30);   // digits, 0..9
         [8'h41:8'h5A]: r.idx = index_type'(c - 8'h37);   // upper case, 10..35
         [8'h61:8'h7A]: r.idx = index_type'(c - 8'h3D);   // lower case, 36..61
         8'h20:         r.idx = 7'd62;                    // space
         8'h2E:         r.idx = 7'd63;                    // full stop
         8'h2C:         r.idx = 7'd64;                    // comma
         8'h3B:         r.idx = 7'd65;                    // semicolon
         8'h2D:         r.idx = 7'd66;                    // hyphen
         default:       r.hit = 1'b0;
      endcase
      return r;
   endfunction

   // Alphabet index back to its byte
   function automatic char_type index_to_char(input index_type i);
      char_type c;
      case (i) inside
         [7'd0:7'd9]:   c = char_type'(i) + 8'h30;
         [7'd10:7'd35]: c = char_type'(i) + 8'h37;
         [7'd36:7'd61]: c = char_type'(i) + 8'h3D;
         7'd62:         c = 8'h20;
         7'd63:         c = 8'h2E;
         7'd64:         c = 8'h2C;
         7'd65:         c = 8'h3B;
         default:       c = 8'h2D;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/ccgo_channels.sv
// Plaintext input channel
interface ccgo_req_if;
   logic                 valid;
   logic                 ready;
   ccgo_pkg::char_type   in_char;

   modport source (output valid, output in_char, input ready);
   modport sink   (input valid, input in_char, output ready);
endinterface

// Cipher output channel
interface ccgo_rsp_if;
   logic                 valid;
   logic                 ready;
   ccgo_pkg::char_type   out_char;
   logic                 last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface

// Key register write channel
interface ccgo_csr_if;
   logic                 valid;
   logic                 ready;
   ccgo_pkg::char_type   key_char;

   modport source (output valid, output key_char, input ready);
   modport sink   (input valid, input key_char, output ready);
endinterface

>>> rtl/caesar_cipher_grouped_output.sv
// Caesar cipher over a 67-symbol alphabet (digits, A-Z, a-z, space and . , ; -)
// with grouped output. One byte is taken on req_bus every cycle while the
// internal queue has room; bytes outside the alphabet are consumed and give no
// result. Each alphabet byte gives its cipher byte on rsp_bus, followed by an
// underscore after every 6th symbol or a newline after every 48th; last marks
// the final result of a byte. rsp_bus delivers one result per cycle from its
// output register while ready is high; a byte with a separator gives two results
// and one without gives one; the output port limits sustained rate. A byte is
// held in the queue, then in the output register. The key is to be written over
// csr_bus (always ready) only while the block is idle, which the block does not
// enforce; a key outside the alphabet, or the reset key '0', gives no shift.
module caesar_cipher_grouped_output #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   ccgo_req_if.sink  req_bus,
   ccgo_rsp_if.source rsp_bus,
   ccgo_csr_if.sink  csr_bus
);

   ccgo_pkg::entry_type push_entry, pop_entry;
   logic                push_valid, push_ready, pop_valid, pop_ready;

   // Front: classify, encrypt, count symbols
   ccgo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // Decoupling queue
   ccgo_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_entry (push_entry),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // Back: emit symbol and separator
   ccgo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_entry (pop_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

>>> rtl/ccgo_front.sv
module ccgo_front (
   input  logic                clock,
   input  logic                reset,
   ccgo_req_if.sink            req_bus,
   ccgo_csr_if.sink            csr_bus,
   output ccgo_pkg::entry_type push_entry,
   output logic                push_valid,
   input  logic                push_ready
);

   localparam logic [ccgo_pkg::IDX_W:0] ALPHA_MOD = (ccgo_pkg::IDX_W+1)'(ccgo_pkg::ALPHA_SIZE);
   localparam logic [ccgo_pkg::LINE_W:0] LINE_END =
      (ccgo_pkg::LINE_W+1)'(ccgo_pkg::LINE_SYMBOLS);
   localparam logic [ccgo_pkg::GROUP_W-1:0] GROUP_END =
      ccgo_pkg::GROUP_W'(ccgo_pkg::GROUP_SYMBOLS - 1);

   ccgo_pkg::index_type          shift_ff;
   logic [ccgo_pkg::LINE_W-1:0]  line_ff, line_in;
   logic [ccgo_pkg::GROUP_W-1:0] group_ff, group_in;

   ccgo_pkg::lookup_type         in_lu, key_lu;
   logic [ccgo_pkg::IDX_W:0]     sum;
   logic [ccgo_pkg::LINE_W:0]    line_next;
   logic                         line_wrap, group_wrap, push_xfer;

   assign csr_bus.ready = 1'b1;
   assign key_lu        = ccgo_pkg::char_lookup(csr_bus.key_char);

   // Shift register: key index, zero for a key outside the alphabet
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (csr_bus.valid) begin
         shift_ff <= key_lu.hit ? key_lu.idx : '0;
      end
   end

   // Classify and encrypt
   always_comb begin
      in_lu      = ccgo_pkg::char_lookup(req_bus.in_char);
      sum        = {1'b0, in_lu.idx} + {1'b0, shift_ff};
      line_next  = {1'b0, line_ff} + 1'b1;
      line_wrap  = (line_next >= LINE_END);
      group_wrap = (group_ff == GROUP_END);

      push_entry.sym_idx = (sum >= ALPHA_MOD) ? ccgo_pkg::IDX_W'(sum - ALPHA_MOD)
                                              : ccgo_pkg::IDX_W'(sum);
      if (line_wrap) begin
         push_entry.sep = ccgo_pkg::SEP_NEWLINE;
      end else if (group_wrap) begin
         push_entry.sep = ccgo_pkg::SEP_UNDERSCORE;
      end else begin
         push_entry.sep = ccgo_pkg::SEP_NONE;
      end

      // Bytes outside the alphabet are taken and dropped
      req_bus.ready = push_ready;
      push_valid    = req_bus.valid && in_lu.hit;
      push_xfer     = push_valid && push_ready;

      line_in  = line_wrap ? '0 : ccgo_pkg::LINE_W'(line_next);
      group_in = (line_wrap || group_wrap) ? '0 : group_ff + 1'b1;
   end

   // Symbol counters, per line and per group
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= '0;
         group_ff <= '0;
      end else if (push_xfer) begin
         line_ff  <= line_in;
         group_ff <= group_in;
      end
   end

endmodule

>>> rtl/ccgo_queue.sv
module ccgo_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  ccgo_pkg::entry_type push_entry,
   input  logic                push_valid,
   output logic                push_ready,
   output ccgo_pkg::entry_type pop_entry,
   output logic                pop_valid,
   input  logic                pop_ready
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ccgo_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push_xfer, pop_xfer;

   always_comb begin
      push_ready = (count_ff != FULL_CNT);
      pop_valid  = (count_ff != '0);
      pop_entry  = slot_ff[rd_ptr_ff];
      push_xfer  = push_valid && push_ready;
      pop_xfer   = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      if (push_xfer) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push_xfer) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/ccgo_back.sv
module ccgo_back (
   input  logic                clock,
   input  logic                reset,
   input  ccgo_pkg::entry_type pop_entry,
   input  logic                pop_valid,
   output logic                pop_ready,
   ccgo_rsp_if.source          rsp_bus
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic               phase_ff, phase_in;      // high: separator of head entry is next
   ccgo_pkg::char_type out_char_ff, out_char_in;
   logic               last_ff, last_in;
   ccgo_pkg::char_type sep_char;
   logic               load;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_char = out_char_ff;
   assign rsp_bus.last     = last_ff;

   // Pick the next result: the symbol, then its separator if any
   always_comb begin
      case (pop_entry.sep)
         ccgo_pkg::SEP_NEWLINE: sep_char = ccgo_pkg::SEP_LINE;
         default:               sep_char = ccgo_pkg::SEP_GROUP;
      endcase

      load         = !rsp_valid_ff || rsp_bus.ready;
      pop_ready    = load && (phase_ff || (pop_entry.sep == ccgo_pkg::SEP_NONE));
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      out_char_in  = out_char_ff;
      last_in      = last_ff;

      if (load) begin
         rsp_valid_in = pop_valid;
         if (pop_valid) begin
            if (phase_ff) begin
               out_char_in = sep_char;
               last_in     = 1'b1;
               phase_in    = 1'b0;
            end else begin
               out_char_in = ccgo_pkg::index_to_char(pop_entry.sym_idx);
               last_in     = (pop_entry.sep == ccgo_pkg::SEP_NONE);
               phase_in    = (pop_entry.sep != ccgo_pkg::SEP_NONE);
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
   end

endmodule

>>> rtl/ccgo_checker.sv
module ccgo_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ccgo_pkg::char_type out_char,
   input logic               last
);

   // Valid holds until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // Payload holds while stalled
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_char) && $stable(last))
      else $error("rsp payload changed while stalled");

   // Nothing to deliver straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

   // A separator always closes the results of its byte
   a_sep_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_char == ccgo_pkg::SEP_GROUP || out_char == ccgo_pkg::SEP_LINE)
      |-> last)
      else $error("separator without last");

   // A non-final result is a cipher symbol followed by a separator
   a_sym_then_sep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> rsp_valid && last)
      else $error("separator not ready after its symbol");

endmodule

bind caesar_cipher_grouped_output ccgo_checker u_ccgo_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_char  (rsp_bus.out_char),
   .last      (rsp_bus.last)
);
